>>> rtl/cvs_pkg.sv
package cvs_pkg;

  // word codes
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_STRIKE = 1'b1;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_INV_RATE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B0  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_A1  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_A2  = 2'd3;

  localparam logic        [19:0] RST_INV_RATE = 20'd89478;
  localparam logic signed [31:0] RST_COEF_B0  = 32'sd41543000;
  localparam logic signed [31:0] RST_COEF_A1  = -32'sd534305000;
  localparam logic signed [31:0] RST_COEF_A2  = 32'sd990654000;

  // fixed gains: 0.4 and the decays in Q0.24, output mix gains in Q.30
  localparam logic signed [31:0] SCALE_WASH = 32'sd6710886;
  localparam logic signed [31:0] DECAY_PING = 32'sd16768829;
  localparam logic signed [31:0] DECAY_WASH = 32'sd16773857;
  localparam logic signed [31:0] GAIN_PING  = 32'sd429496730;
  localparam logic signed [31:0] GAIN_WASH  = 32'sd107374182;

  // oscillator frequency table
  localparam int NUM_FREQ   = 6;
  localparam int FREQ_IDX_W = 3;

  function automatic logic [10:0] freq_hz(input logic [FREQ_IDX_W-1:0] idx);
    logic [10:0] f;
    case (idx)
      3'd0:    f = 11'd230;
      3'd1:    f = 11'd310;
      3'd2:    f = 11'd455;
      3'd3:    f = 11'd580;
      3'd4:    f = 11'd920;
      3'd5:    f = 11'd1350;
      default: f = 11'd0;
    endcase
    return f;
  endfunction

  // microcode fields
  typedef enum logic [3:0] {
    MUL_NONE, MUL_FREQ, MUL_MIX_PING, MUL_MIX_WASH, MUL_PING_DECAY, MUL_WASH_DECAY,
    MUL_B0_X, MUL_A1_FOUT, MUL_A2_FOUT, MUL_FOUT_GAIN, MUL_WSIG_GAIN, MUL_STRIKE
  } mul_op_t;

  typedef enum logic [3:0] {
    WR_NONE, WR_MIX, WR_PING_IN, WR_WASH_IN, WR_PING_SHIFT, WR_WASH_SHIFT,
    WR_FOUT, WR_MEM_ONE, WR_MEM_TWO, WR_SAMPLE, WR_PING_VEL
  } wr_op_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_NEG, ACC_ADD, ACC_SUB, ACC_ROUND, ACC_TMP_NEG
  } acc_op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT, SEQ_LOOP, SEQ_DONE
  } seq_op_t;

  typedef struct packed {
    mul_op_t mul_op;
    wr_op_t  wr_op;
    acc_op_t acc_op;
    seq_op_t seq_op;
  } ctl_t;

  typedef struct packed {
    logic start;
    logic strike;
    logic stall;
    logic osc_last;
  } seq_cmd_t;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] TICK_ENTRY   = 4'd0;
  localparam logic [PC_W-1:0] STRIKE_ENTRY = 4'd14;

  localparam ctl_t IDLE_WORD = '{MUL_NONE, WR_NONE, ACC_HOLD, SEQ_DONE};

  // control store
  function automatic ctl_t ctl_word(input logic [PC_W-1:0] pc);
    ctl_t w;
    case (pc)
      4'd0:    w = '{MUL_FREQ,       WR_MIX,        ACC_HOLD,    SEQ_LOOP};
      4'd1:    w = '{MUL_MIX_PING,   WR_NONE,       ACC_HOLD,    SEQ_NEXT};
      4'd2:    w = '{MUL_MIX_WASH,   WR_PING_IN,    ACC_HOLD,    SEQ_NEXT};
      4'd3:    w = '{MUL_PING_DECAY, WR_WASH_IN,    ACC_HOLD,    SEQ_NEXT};
      4'd4:    w = '{MUL_WASH_DECAY, WR_PING_SHIFT, ACC_HOLD,    SEQ_NEXT};
      4'd5:    w = '{MUL_B0_X,       WR_WASH_SHIFT, ACC_HOLD,    SEQ_NEXT};
      4'd6:    w = '{MUL_NONE,       WR_FOUT,       ACC_NEG,     SEQ_NEXT};
      4'd7:    w = '{MUL_A1_FOUT,    WR_NONE,       ACC_HOLD,    SEQ_NEXT};
      4'd8:    w = '{MUL_A2_FOUT,    WR_NONE,       ACC_TMP_NEG, SEQ_NEXT};
      4'd9:    w = '{MUL_FOUT_GAIN,  WR_MEM_ONE,    ACC_SUB,     SEQ_NEXT};
      4'd10:   w = '{MUL_WSIG_GAIN,  WR_MEM_TWO,    ACC_LOAD,    SEQ_NEXT};
      4'd11:   w = '{MUL_NONE,       WR_NONE,       ACC_ADD,     SEQ_NEXT};
      4'd12:   w = '{MUL_NONE,       WR_NONE,       ACC_ROUND,   SEQ_NEXT};
      4'd13:   w = '{MUL_NONE,       WR_SAMPLE,     ACC_HOLD,    SEQ_DONE};
      4'd14:   w = '{MUL_STRIKE,     WR_PING_VEL,   ACC_HOLD,    SEQ_NEXT};
      4'd15:   w = '{MUL_NONE,       WR_WASH_SHIFT, ACC_HOLD,    SEQ_DONE};
      default: w = IDLE_WORD;
    endcase
    return w;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647)
      r = 32'sh7FFFFFFF;
    else if (v < -36'sd2147483648)
      r = 32'sh80000000;
    else
      r = v[31:0];
    return r;
  endfunction

endpackage

>>> rtl/cymbal_voice_synth.sv
// tick word: the sample is written by its last step, which ends the word
// strike word: no sample; one word is in work at a time, set by the shared
// 32x32 multiplier that every product of the program passes through
// the last step waits while an earlier sample is still unread
// synchronous reset clears phases, envelopes and filter state, reloads power-on coefficients
module cymbal_voice_synth import cvs_pkg::*; #(
  parameter int NUM_OSC  = 6,
  parameter int OUT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       command,
  input  logic [15:0]                velocity,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_BITS-1:0] sample
);

  localparam int OSC_W     = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
  localparam int MIX_W     = $clog2(NUM_OSC + 1) + 1;
  localparam int RND_SHIFT = 55 - OUT_BITS;
  localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (RND_SHIFT - 1);
  localparam logic signed [63:0] LIM_HI   = (64'sd1 <<< (OUT_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] LIM_LO   = -(64'sd1 <<< (OUT_BITS - 1));
  localparam logic signed [MIX_W-1:0] MIX_UP = MIX_W'(1);
  localparam logic signed [MIX_W-1:0] MIX_DN = {MIX_W{1'b1}};

  // configuration registers
  logic        [19:0] inv_rate;
  logic signed [31:0] coef_b0;
  logic signed [31:0] coef_a1;
  logic signed [31:0] coef_a2;

  // voice state
  logic [31:0]             osc_phase [NUM_OSC];
  logic [OSC_W-1:0]        osc_cnt;
  logic [FREQ_IDX_W-1:0]   freq_idx;
  logic                    pend;
  logic [OSC_W-1:0]        pend_idx;
  logic signed [MIX_W-1:0] mix;
  logic [23:0]             ping_level;
  logic [23:0]             wash_level;
  logic signed [31:0]      filter_mem_one;
  logic signed [31:0]      filter_mem_two;

  // working registers
  logic [15:0]        vel;
  logic signed [31:0] ping_in;
  logic signed [31:0] wash_in;
  logic signed [31:0] filt_out;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [63:0] tmp;

  logic               accept;
  logic               osc_last;
  logic               stall;
  logic               busy;
  ctl_t               ctl;
  seq_cmd_t           cmd;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod_next;
  logic signed [35:0] fout_sum;
  logic signed [35:0] mem_one_sum;
  logic signed [35:0] mem_two_val;
  logic signed [63:0] y_full;
  logic signed [OUT_BITS-1:0] y_sat;

  assign accept   = in_valid && in_ready;
  assign in_ready = !busy;
  assign osc_last = (osc_cnt == OSC_W'(NUM_OSC - 1));
  // hold the final step while the previous sample has not been taken
  assign stall    = (ctl.wr_op == WR_SAMPLE) && out_valid && !out_ready;

  assign cmd.start    = accept;
  assign cmd.strike   = (command == CMD_STRIKE);
  assign cmd.stall    = stall;
  assign cmd.osc_last = osc_last;

  cvs_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .ctl  (ctl),
    .busy (busy)
  );

  // shared multiplier operand selection
  always_comb begin
    case (ctl.mul_op)
      MUL_FREQ: begin
        mul_a = {21'd0, freq_hz(freq_idx)};
        mul_b = {12'd0, inv_rate};
      end
      MUL_MIX_PING: begin
        mul_a = {{(32 - MIX_W){mix[MIX_W-1]}}, mix};
        mul_b = {8'd0, ping_level};
      end
      MUL_MIX_WASH: begin
        mul_a = {{(32 - MIX_W){mix[MIX_W-1]}}, mix};
        mul_b = {8'd0, wash_level};
      end
      MUL_PING_DECAY: begin
        mul_a = {8'd0, ping_level};
        mul_b = DECAY_PING;
      end
      MUL_WASH_DECAY: begin
        mul_a = {8'd0, wash_level};
        mul_b = DECAY_WASH;
      end
      MUL_B0_X: begin
        mul_a = coef_b0;
        mul_b = ping_in;
      end
      MUL_A1_FOUT: begin
        mul_a = coef_a1;
        mul_b = filt_out;
      end
      MUL_A2_FOUT: begin
        mul_a = coef_a2;
        mul_b = filt_out;
      end
      MUL_FOUT_GAIN: begin
        mul_a = filt_out;
        mul_b = GAIN_PING;
      end
      MUL_WSIG_GAIN: begin
        mul_a = wash_in;
        mul_b = GAIN_WASH;
      end
      MUL_STRIKE: begin
        mul_a = {8'd0, vel, 8'd0};
        mul_b = SCALE_WASH;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_next = mul_a * mul_b;

  // filter sums: arithmetic shifts give the floor of each product by 2^30
  assign fout_sum    = 36'(prod >>> 30) + 36'(filter_mem_one);
  assign mem_one_sum = 36'(tmp >>> 30) + 36'(filter_mem_two);
  assign mem_two_val = 36'(acc >>> 30);

  // output rounding already added, now shift and clamp
  assign y_full = acc >>> RND_SHIFT;

  always_comb begin
    if (y_full > LIM_HI)
      y_sat = LIM_HI[OUT_BITS-1:0];
    else if (y_full < LIM_LO)
      y_sat = LIM_LO[OUT_BITS-1:0];
    else
      y_sat = y_full[OUT_BITS-1:0];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_rate <= RST_INV_RATE;
      coef_b0  <= RST_COEF_B0;
      coef_a1  <= RST_COEF_A1;
      coef_a2  <= RST_COEF_A2;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_INV_RATE: inv_rate <= cfg_wdata[19:0];
        REG_COEF_B0:  coef_b0  <= cfg_wdata[31:0];
        REG_COEF_A1:  coef_a1  <= cfg_wdata[31:0];
        REG_COEF_A2:  coef_a2  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // product register, loaded with one product in each step that uses the multiplier
  always_ff @(posedge clk) begin
    if (ctl.mul_op != MUL_NONE)
      prod <= prod_next;
  end

  // word capture and per-word working registers
  always_ff @(posedge clk) begin
    if (accept)
      vel <= velocity;
    case (ctl.wr_op)
      WR_PING_IN: ping_in  <= prod[31:0];
      WR_WASH_IN: wash_in  <= prod[31:0];
      WR_FOUT:    filt_out <= sat32(fout_sum);
      default: ;
    endcase
    case (ctl.acc_op)
      ACC_LOAD:    acc <= prod;
      ACC_NEG:     acc <= -prod;
      ACC_ADD:     acc <= acc + prod;
      ACC_SUB:     acc <= acc - prod;
      ACC_ROUND:   acc <= acc + RND_HALF;
      ACC_TMP_NEG: tmp <= -prod;
      default: ;
    endcase
  end

  // voice state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_OSC; i++)
        osc_phase[i] <= '0;
      osc_cnt        <= '0;
      freq_idx       <= '0;
      pend           <= 1'b0;
      pend_idx       <= '0;
      mix            <= '0;
      ping_level     <= '0;
      wash_level     <= '0;
      filter_mem_one <= '0;
      filter_mem_two <= '0;
      out_valid      <= 1'b0;
    end else begin
      // a new sample replaces one taken in the same cycle
      if ((ctl.wr_op == WR_SAMPLE) && !stall)
        out_valid <= 1'b1;
      else if (out_valid && out_ready)
        out_valid <= 1'b0;

      if (accept) begin
        mix      <= '0;
        osc_cnt  <= '0;
        freq_idx <= '0;
      end

      // phase advance is applied in the cycle after the step that forms its product
      if (pend)
        osc_phase[pend_idx] <= osc_phase[pend_idx] + prod[31:0];
      pend <= (ctl.mul_op == MUL_FREQ);

      if (ctl.mul_op == MUL_FREQ) begin
        pend_idx <= osc_cnt;
        osc_cnt  <= osc_last ? '0 : osc_cnt + OSC_W'(1);
        freq_idx <= (freq_idx == FREQ_IDX_W'(NUM_FREQ - 1)) ? '0
                                                           : freq_idx + FREQ_IDX_W'(1);
      end

      case (ctl.wr_op)
        // square wave: top phase bit set counts as minus one
        WR_MIX:        mix <= mix + (osc_phase[osc_cnt][31] ? MIX_DN : MIX_UP);
        WR_PING_SHIFT: ping_level <= prod[47:24];
        WR_WASH_SHIFT: wash_level <= prod[47:24];
        WR_PING_VEL:   ping_level <= {vel, 8'd0};
        WR_MEM_ONE:    filter_mem_one <= sat32(mem_one_sum);
        WR_MEM_TWO:    filter_mem_two <= sat32(mem_two_val);
        WR_SAMPLE: begin
          if (!stall)
            sample <= y_sat;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/cvs_useq.sv
module cvs_useq import cvs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  seq_cmd_t cmd,
  output ctl_t     ctl,
  output logic     busy
);

  logic [PC_W-1:0] pc;
  ctl_t            word;

  assign word = ctl_word(pc);
  assign ctl  = busy ? word : IDLE_WORD;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= TICK_ENTRY;
    end else if (!busy) begin
      if (cmd.start) begin
        busy <= 1'b1;
        pc   <= cmd.strike ? STRIKE_ENTRY : TICK_ENTRY;
      end
    end else if (!cmd.stall) begin
      case (word.seq_op)
        SEQ_NEXT: pc <= pc + PC_W'(1);
        SEQ_LOOP: begin
          if (cmd.osc_last)
            pc <= pc + PC_W'(1);
        end
        SEQ_DONE: busy <= 1'b0;
        default:  busy <= 1'b0;
      endcase
    end
  end

endmodule

>>> rtl/cvs_checker.sv
module cvs_checker import cvs_pkg::*; #(
  parameter int OUT_BITS = 16
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       command,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [OUT_BITS-1:0] sample
);

  // a waiting sample is neither dropped nor changed
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample))
    else $error("sample lost or changed while stalled");

  // a word always occupies the block: ready is low in the cycle after acceptance
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after acceptance");

  // no sample rises while a strike word is in work
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (command == CMD_STRIKE)
      |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("sample after a strike");

  // a new sample only comes out of work in progress
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("sample appeared while idle");

endmodule

bind cymbal_voice_synth cvs_checker #(.OUT_BITS(OUT_BITS)) u_cvs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .command   (command),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .sample    (sample)
);
